### rtl/iph_pkg.sv
// Package with phase codes, status codes and helpers for the image header parser.
package iph_pkg;

  localparam int unsigned PhaseW = 5;
  localparam int unsigned PosW   = 8;
  localparam int unsigned SkipW  = 16;
  localparam int unsigned DimW   = 32;
  localparam int unsigned DepthW = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned FmtW   = 2;

  localparam logic [PhaseW-1:0] PH_START   = 5'd0;
  localparam logic [PhaseW-1:0] PH_BMP     = 5'd1;
  localparam logic [PhaseW-1:0] PH_GIF     = 5'd2;
  localparam logic [PhaseW-1:0] PH_JHDR    = 5'd3;
  localparam logic [PhaseW-1:0] PH_JSKIP   = 5'd4;
  localparam logic [PhaseW-1:0] PH_JMARK   = 5'd5;
  localparam logic [PhaseW-1:0] PH_JTYPE   = 5'd6;
  localparam logic [PhaseW-1:0] PH_JSEGLEN = 5'd7;
  localparam logic [PhaseW-1:0] PH_JSOF    = 5'd8;
  localparam logic [PhaseW-1:0] PH_PNG     = 5'd9;

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_BAD   = 2'd1;
  localparam logic [StatW-1:0] ST_TRUNC = 2'd2;
  localparam logic [StatW-1:0] ST_ZERO  = 2'd3;

  localparam logic [FmtW-1:0] FMT_BMP  = 2'd0;
  localparam logic [FmtW-1:0] FMT_GIF  = 2'd1;
  localparam logic [FmtW-1:0] FMT_JPEG = 2'd2;
  localparam logic [FmtW-1:0] FMT_PNG  = 2'd3;

  localparam logic [7:0] MARK_FILL = 8'hFF;
  localparam logic [7:0] MARK_SOI  = 8'hD8;
  localparam logic [7:0] MARK_APP0 = 8'hE0;
  localparam logic [7:0] MARK_EOI  = 8'hD9;
  localparam logic [7:0] MARK_SOS  = 8'hDA;

  function automatic logic is_frame_marker(input logic [7:0] t);
    is_frame_marker = (t[7:4] == 4'hC) && (t != 8'hC4) && (t != 8'hC8) && (t != 8'hCC);
  endfunction

  function automatic logic [7:0] png_sig(input logic [2:0] i);
    logic [7:0] v;
    unique case (i)
      3'd0: v = 8'h89;
      3'd1: v = 8'h50;
      3'd2: v = 8'h4E;
      3'd3: v = 8'h47;
      3'd4: v = 8'h0D;
      3'd5: v = 8'h0A;
      3'd6: v = 8'h1A;
      default: v = 8'h0A;
    endcase
    png_sig = v;
  endfunction

  function automatic logic [7:0] ihdr_id(input logic [1:0] i);
    logic [7:0] v;
    unique case (i)
      2'd0: v = 8'h49;
      2'd1: v = 8'h48;
      2'd2: v = 8'h44;
      default: v = 8'h52;
    endcase
    ihdr_id = v;
  endfunction

  function automatic logic [7:0] jfif_id(input logic [2:0] i);
    logic [7:0] v;
    unique case (i)
      3'd0: v = 8'h4A;
      3'd1: v = 8'h46;
      3'd2: v = 8'h49;
      3'd3: v = 8'h46;
      default: v = 8'h00;
    endcase
    jfif_id = v;
  endfunction

  function automatic logic [7:0] jpeg_head(input logic [1:0] i);
    logic [7:0] v;
    unique case (i)
      2'd0: v = MARK_FILL;
      2'd1: v = MARK_SOI;
      2'd2: v = MARK_FILL;
      default: v = MARK_APP0;
    endcase
    jpeg_head = v;
  endfunction

endpackage

### rtl/image_header_parser_top.sv
// Top level of the image header parser: input register, header parse logic and result register.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid_i/in_stall_o    data_byte_i, last_byte_i
//  out       source     out_valid_o/out_stall_i  status_o, width_o, height_o, bits_per_pixel_o
//  cfg       sink       cfg_we_i                 cfg_wdata_i (format select)
//
// One word is taken per cycle while in_stall_o is low.
// The rate is set by the combinational parse step between the input and result registers.
// Reset clears the input and result valid flags, the parse state and the format select.
// While a result waits under out_stall_i, one more word is held in the input register and
// in_stall_o rises only when that register is also full.
module image_header_parser_top
  import iph_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [FmtW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [StatW-1:0]  status_o,
  output logic [DimW-1:0]   width_o,
  output logic [DimW-1:0]   height_o,
  output logic [DepthW-1:0] bits_per_pixel_o
);

  logic [FmtW-1:0]   fmt_q;
  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              last_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [SkipW-1:0]  skip_q, skip_d;
  logic [DimW-1:0]   wacc_q, wacc_d;
  logic [DimW-1:0]   hacc_q, hacc_d;
  logic [DepthW-1:0] dacc_q, dacc_d;
  logic [7:0]        prec_q, prec_d;
  logic              given_q, given_d;
  logic              out_valid_q;
  logic [StatW-1:0]  stat_q, stat_d;
  logic [DimW-1:0]   wout_q, wout_d;
  logic [DimW-1:0]   hout_q, hout_d;
  logic [DepthW-1:0] dout_q, dout_d;
  logic              fire;
  logic              advance;
  logic              in_accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    logic [PhaseW-1:0] ph;
    logic [PosW-1:0]   p;
    logic [7:0]        b;
    logic              done;
    logic [StatW-1:0]  st;
    logic [SkipW-1:0]  len;
    logic [2:0]        fac;
    phase_d = phase_q;
    pos_d   = pos_q;
    skip_d  = skip_q;
    wacc_d  = wacc_q;
    hacc_d  = hacc_q;
    dacc_d  = dacc_q;
    prec_d  = prec_q;
    given_d = given_q;
    fire    = 1'b0;
    stat_d  = ST_OK;
    wout_d  = '0;
    hout_d  = '0;
    dout_d  = '0;
    b       = byte_q;
    done    = 1'b0;
    st      = ST_OK;
    len     = '0;
    fac     = 3'd1;
    ph      = phase_q;
    p       = pos_q;

    if (!given_q) begin
      if (phase_q == PH_START) begin
        unique case (fmt_q)
          FMT_BMP:  ph = PH_BMP;
          FMT_GIF:  ph = PH_GIF;
          FMT_JPEG: ph = PH_JHDR;
          default:  ph = PH_PNG;
        endcase
        p = '0;
      end
      phase_d = ph;
      pos_d   = p + 8'd1;

      unique case (ph)
        PH_BMP: begin
          if ((p == 8'd0 && b != 8'h42) || (p == 8'd1 && b != 8'h4D)) begin
            done = 1'b1;
            st   = ST_BAD;
          end else begin
            if (p >= 8'd18 && p <= 8'd21) begin
              wacc_d = wacc_q | (DimW'(b) << {p[1:0] - 2'd2, 3'b000});
            end
            if (p >= 8'd22 && p <= 8'd25) begin
              hacc_d = hacc_q | (DimW'(b) << {p[1:0] - 2'd2, 3'b000});
            end
            if (p == 8'd28) dacc_d = DepthW'(b);
            if (p == 8'd29) begin
              dacc_d = {b, dacc_q[7:0]};
              done   = 1'b1;
            end
          end
        end
        PH_GIF: begin
          if ((p == 8'd0 && b != 8'h47) || (p == 8'd1 && b != 8'h49) ||
              (p == 8'd2 && b != 8'h46)) begin
            done = 1'b1;
            st   = ST_BAD;
          end else begin
            if (p == 8'd6) wacc_d = DimW'(b);
            if (p == 8'd7) wacc_d = wacc_q | (DimW'(b) << 8);
            if (p == 8'd8) hacc_d = DimW'(b);
            if (p == 8'd9) hacc_d = hacc_q | (DimW'(b) << 8);
            if (p == 8'd10) begin
              dacc_d = (b[6:4] > b[2:0]) ? DepthW'({1'b0, b[6:4]} + 4'd1)
                                         : DepthW'({1'b0, b[2:0]} + 4'd1);
              done   = 1'b1;
            end
          end
        end
        PH_PNG: begin
          if ((p <= 8'd7 && b != png_sig(p[2:0])) ||
              (p >= 8'd12 && p <= 8'd15 && b != ihdr_id(p[1:0]))) begin
            done = 1'b1;
            st   = ST_BAD;
          end else begin
            if (p >= 8'd16 && p <= 8'd19) wacc_d = {wacc_q[23:0], b};
            if (p >= 8'd20 && p <= 8'd23) hacc_d = {hacc_q[23:0], b};
            if (p == 8'd24) dacc_d = DepthW'(b);
            if (p == 8'd25) begin
              done = 1'b1;
              unique case (b)
                8'd0, 8'd3: fac = 3'd1;
                8'd2:       fac = 3'd3;
                8'd4:       fac = 3'd2;
                8'd6:       fac = 3'd4;
                default: begin
                  fac = 3'd1;
                  st  = ST_BAD;
                end
              endcase
              dacc_d = DepthW'(dacc_q * fac);
            end
          end
        end
        PH_JHDR: begin
          len = {skip_q[15:8], b};
          if ((p <= 8'd3 && b != jpeg_head(p[1:0])) ||
              (p >= 8'd6 && p <= 8'd10 && b != jfif_id(3'(p - 8'd6)))) begin
            done = 1'b1;
            st   = ST_BAD;
          end else begin
            if (p == 8'd4) skip_d = {b, 8'h00};
            if (p == 8'd5) skip_d = len;
            if (p == 8'd10) begin
              if (skip_q < 16'd7) begin
                done = 1'b1;
                st   = ST_BAD;
              end else begin
                skip_d  = skip_q - 16'd7;
                phase_d = (skip_q != 16'd7) ? PH_JSKIP : PH_JMARK;
              end
            end
          end
        end
        PH_JSKIP: begin
          skip_d = skip_q - 16'd1;
          if (skip_q == 16'd1) phase_d = PH_JMARK;
        end
        PH_JMARK: begin
          if (b != MARK_FILL) begin
            done = 1'b1;
            st   = ST_BAD;
          end else begin
            phase_d = PH_JTYPE;
          end
        end
        PH_JTYPE: begin
          if (b != MARK_FILL) begin
            if (b == MARK_EOI || b == MARK_SOS) begin
              done = 1'b1;
              st   = ST_BAD;
            end else begin
              phase_d = is_frame_marker(b) ? PH_JSOF : PH_JSEGLEN;
              pos_d   = '0;
            end
          end
        end
        PH_JSEGLEN: begin
          len = {skip_q[15:8], b};
          if (p == 8'd0) begin
            skip_d = {b, 8'h00};
          end else if (len < 16'd2) begin
            skip_d = len;
            done   = 1'b1;
            st     = ST_BAD;
          end else begin
            skip_d  = len - 16'd2;
            phase_d = (len != 16'd2) ? PH_JSKIP : PH_JMARK;
          end
        end
        PH_JSOF: begin
          if (p == 8'd2) prec_d = b;
          if (p == 8'd3) hacc_d = DimW'(b);
          if (p == 8'd4) hacc_d = {hacc_q[23:0], b};
          if (p == 8'd5) wacc_d = DimW'(b);
          if (p == 8'd6) wacc_d = {wacc_q[23:0], b};
          if (p == 8'd7) begin
            dacc_d = DepthW'(b) * DepthW'(prec_q);
            done   = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
          st   = ST_BAD;
        end
      endcase

      if (done) begin
        fire    = 1'b1;
        given_d = 1'b1;
        if (st == ST_OK) begin
          wout_d = wacc_d;
          hout_d = hacc_d;
          dout_d = dacc_d;
          stat_d = (wacc_d == '0 || hacc_d == '0 || dacc_d == '0) ? ST_ZERO : ST_OK;
        end else begin
          stat_d = st;
        end
      end
    end

    if (last_q) begin
      if (!given_d) begin
        fire   = 1'b1;
        stat_d = ST_TRUNC;
        wout_d = '0;
        hout_d = '0;
        dout_d = '0;
      end
      phase_d = PH_START;
      pos_d   = '0;
      skip_d  = '0;
      wacc_d  = '0;
      hacc_d  = '0;
      dacc_d  = '0;
      prec_d  = '0;
      given_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FMT_BMP;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_START;
      pos_q       <= '0;
      skip_q      <= '0;
      wacc_q      <= '0;
      hacc_q      <= '0;
      dacc_q      <= '0;
      prec_q      <= '0;
      given_q     <= 1'b0;
    end else begin
      if (cfg_we_i) fmt_q <= cfg_wdata_i;
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        skip_q  <= skip_d;
        wacc_q  <= wacc_d;
        hacc_q  <= hacc_d;
        dacc_q  <= dacc_d;
        prec_q  <= prec_d;
        given_q <= given_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (advance && fire) begin
      stat_q <= stat_d;
      wout_q <= wout_d;
      hout_q <= hout_d;
      dout_q <= dout_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = stat_q;
  assign width_o          = wout_q;
  assign height_o         = hout_q;
  assign bits_per_pixel_o = dout_q;

  a_stall_needs_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  a_error_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BAD || status_o == ST_TRUNC) |->
      width_o == '0 && height_o == '0 && bits_per_pixel_o == '0)
    else $error("error result carries nonzero fields");

  a_ok_fields_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |->
      width_o != '0 && height_o != '0 && bits_per_pixel_o != '0)
    else $error("ok result carries a zero field");

  a_result_marks_file : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && fire && !last_q |=> given_q)
    else $error("result given without marking the file as done");

endmodule
